### rtl/jetc_pkg.sv
// Shared types, register codes and the color table for the Julia escape-time colorizer.
// No dependencies; the modules refer to this package by scoped names.
package jetc_pkg;

  // Input beat: pixel start point z0, signed s3.28
  typedef struct packed {
    logic signed [31:0] start_real;
    logic signed [31:0] start_imag;
  } in_t;

  // Output beat: table color, painted flag and escape step
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        painted;
    logic [15:0] escape_step;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_C_REAL   = 2'd0;
  localparam logic [1:0] CFG_C_IMAG   = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER = 2'd2;

  // Register reset values
  localparam logic signed [31:0] C_REAL_RESET   = 32'sd73374148;
  localparam logic signed [31:0] C_IMAG_RESET   = 32'sd1991791;
  localparam int unsigned        MAX_ITER_RESET = 600;

  localparam int unsigned PALETTE_SIZE = 7;

  // Fixed color table, index already clipped to the last entry
  function automatic rgb_t palette(input logic [2:0] idx);
    rgb_t c;
    case (idx)
      3'd0:    c = '{red: 8'd64,  green: 8'd128, blue: 8'd120};
      3'd1:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      3'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      3'd3:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
      3'd4:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      3'd5:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
      default: c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

### rtl/julia_escape_time_colorizer_unit.sv
// Julia escape-time colorizer: iterative fixed-point core with one shared multiplier.
// Depends on jetc_pkg (beat types, register codes, color table).
//
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one start point z0 per beat.
//   out channel (out_valid_o/out_ready_i/out_data_o): one color beat per input beat.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_addr_i/cfg_data_i): c_real, c_imag,
//   max_iter; always ready, write only while the unit is idle.
// Timing: one item is worked on at a time; in_ready_o is high only when idle.
//   A single 32x32 signed multiplier forms re*re, im*im and re*im in turn, so each
//   iteration of z = z*z + c steps through re^2, im^2, re*im and the update in turn.
//   When the point escapes, a restoring division with $clog2(TABLE_LEN) quotient bits
//   forms the color index.
// Stall: the result sits in an output register; the next item is accepted and
//   iterated while it waits, and the core holds its finished result until the
//   output register frees up.
// Reset: asynchronous, active low; the configuration registers return to their reset
//   values and no beat is pending.
module julia_escape_time_colorizer_unit #(
  parameter int unsigned TABLE_LEN = 7,
  parameter int unsigned FRAC_BITS = 28,
  parameter int unsigned ITER_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jetc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jetc_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_addr_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned TW = $clog2(TABLE_LEN);
  localparam int unsigned NW = ITER_BITS + TW;
  localparam int unsigned CW = (TW > 1) ? $clog2(TW) : 1;
  localparam bit          ESC_EN = (2 * FRAC_BITS + 2) < 64;
  localparam logic [63:0] THR = ESC_EN ? (64'd1 << ((2 * FRAC_BITS + 2) % 64)) : 64'd0;
  localparam logic [TW-1:0] LAST_IDX = TW'(TABLE_LEN - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ_RE, ST_SQ_IM, ST_CHECK, ST_UPDATE, ST_DIV, ST_FIN
  } state_e;

  // Clip to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_e                 state_q;
  logic signed [31:0]     c_real_q, c_imag_q;
  logic [ITER_BITS-1:0]   max_iter_q;
  logic signed [31:0]     re_q, im_q;
  logic signed [63:0]     rr_q, ii_q, ri_q, diff_q;
  logic [ITER_BITS-1:0]   k_q;
  logic                   first_q, esc_q;
  logic [NW-1:0]          rem_q, dvs_q;
  logic [TW-1:0]          quot_q;
  logic [CW-1:0]          dcnt_q;
  logic                   out_valid_q;
  jetc_pkg::out_t         out_q;

  // Shared multiplier operand select
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  always_comb begin
    case (state_q)
      ST_SQ_RE: begin mul_a = re_q; mul_b = re_q; end
      ST_SQ_IM: begin mul_a = im_q; mul_b = im_q; end
      default:  begin mul_a = re_q; mul_b = im_q; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Escape test on the squares of the current z
  logic [63:0] mag;
  logic        mag_gt;
  assign mag    = rr_q + ii_q;
  assign mag_gt = ESC_EN && (mag > THR);

  logic              last_iter;
  logic [ITER_BITS:0] k_inc;
  assign k_inc     = {1'b0, k_q} + 1'b1;
  assign last_iter = (k_inc == {1'b0, max_iter_q});

  // Update of z: floor shifts, add c, saturate
  logic signed [63:0] nre_w, nim_w;
  assign nre_w = (diff_q >>> FRAC_BITS) + 64'(c_real_q);
  assign nim_w = (ri_q >>> (FRAC_BITS - 1)) + 64'(c_imag_q);

  // Dividend k*(TABLE_LEN-1) for the color index
  logic [NW-1:0] dividend;
  assign dividend = NW'({{TW{1'b0}}, k_q} * NW'(TABLE_LEN - 1));

  // Result assembly
  logic [TW-1:0]         idx;
  logic [TW+2:0]         idx_ext;
  logic [2:0]            idx_clip;
  logic [ITER_BITS-1:0]  step_val;
  logic [ITER_BITS+15:0] step_ext;
  jetc_pkg::rgb_t        color;
  jetc_pkg::out_t        res;
  always_comb begin
    idx      = esc_q ? quot_q : LAST_IDX;
    idx_ext  = {3'b000, idx};
    idx_clip = (idx_ext >= (TW+3)'(jetc_pkg::PALETTE_SIZE)) ?
               3'(jetc_pkg::PALETTE_SIZE - 1) : idx_ext[2:0];
    color    = jetc_pkg::palette(idx_clip);
    step_val = esc_q ? k_q : max_iter_q;
    step_ext = {16'd0, step_val};
    if (esc_q && (k_q == '0)) begin
      res = '0;
    end else begin
      res.red         = color.red;
      res.green       = color.green;
      res.blue        = color.blue;
      res.painted     = 1'b1;
      res.escape_step = step_ext[15:0];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_real_q    <= jetc_pkg::C_REAL_RESET;
      c_imag_q    <= jetc_pkg::C_IMAG_RESET;
      max_iter_q  <= ITER_BITS'(jetc_pkg::MAX_ITER_RESET);
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      esc_q       <= 1'b0;
      k_q         <= '0;
      dcnt_q      <= '0;
    end else begin
      // config writes
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          jetc_pkg::CFG_C_REAL:   c_real_q   <= cfg_data_i;
          jetc_pkg::CFG_C_IMAG:   c_imag_q   <= cfg_data_i;
          jetc_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[ITER_BITS-1:0];
          default: ;
        endcase
      end

      // output beat taken; in ST_FIN the refill below owns the flag
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            re_q    <= in_data_i.start_real;
            im_q    <= in_data_i.start_imag;
            k_q     <= '0;
            first_q <= 1'b1;
            esc_q   <= 1'b0;
            state_q <= (max_iter_q == '0) ? ST_FIN : ST_SQ_RE;
          end
        end
        ST_SQ_RE: begin
          rr_q    <= prod;
          state_q <= ST_SQ_IM;
        end
        ST_SQ_IM: begin
          ii_q    <= prod;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          // re*im for the next update, and test of the step just done
          ri_q    <= prod;
          diff_q  <= rr_q - ii_q;
          first_q <= 1'b0;
          if (first_q) begin
            state_q <= ST_UPDATE;
          end else if (mag_gt) begin
            esc_q   <= 1'b1;
            rem_q   <= dividend;
            dvs_q   <= NW'({{TW{1'b0}}, max_iter_q} << (TW - 1));
            quot_q  <= '0;
            dcnt_q  <= CW'(TW - 1);
            state_q <= (k_q == '0) ? ST_FIN : ST_DIV;
          end else if (last_iter) begin
            state_q <= ST_FIN;
          end else begin
            k_q     <= k_inc[ITER_BITS-1:0];
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          re_q    <= sat32(nre_w);
          im_q    <= sat32(nim_w);
          state_q <= ST_SQ_RE;
        end
        ST_DIV: begin
          // one restoring division step per cycle
          if (rem_q >= dvs_q) begin
            rem_q  <= rem_q - dvs_q;
            quot_q <= TW'({quot_q, 1'b1});
          end else begin
            quot_q <= TW'({quot_q, 1'b0});
          end
          dvs_q <= dvs_q >> 1;
          if (dcnt_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/jetc_color_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Julia escape-time colorizer: mirrors the configuration registers,
// predicts the color beat for every start point and compares it with the output channel.
// Depends on jetc_pkg for the beat types, register codes and register reset values.
module jetc_color_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  jetc_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  jetc_pkg::out_t out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [1:0]     cfg_addr_i,
  input  logic [31:0]    cfg_data_i,
  output int             pending_o,
  output int             fail_count_o
);

  localparam int unsigned TABLE_LEN = 7;
  localparam int unsigned FRAC_BITS = 28;
  // |z|^2 > 4 at the squared scale (2*FRAC_BITS fraction bits)
  localparam logic [63:0] ESCAPE_MAG = 64'd1 << (2 * FRAC_BITS + 2);
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // Mirrored registers
  longint      c_re;
  longint      c_im;
  logic [15:0] iter_limit;

  jetc_pkg::out_t colors_due[$];
  jetc_pkg::out_t want;
  int             fails = 0;

  function automatic longint clip_s32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Color table; anything past the end reads the last entry
  function automatic logic [23:0] shade(input int unsigned idx);
    case (idx)
      0:       return {8'd64, 8'd128, 8'd120};
      1:       return {8'd0, 8'd0, 8'd255};
      2:       return {8'd0, 8'd255, 8'd0};
      3:       return {8'd0, 8'd255, 8'd255};
      4:       return {8'd255, 8'd0, 8'd0};
      5:       return {8'd255, 8'd0, 8'd255};
      default: return {8'd255, 8'd255, 8'd0};
    endcase
  endfunction

  // Iterate z = z*z + c in s3.28 and turn the escape step into a color beat
  function automatic jetc_pkg::out_t color_point(input jetc_pkg::in_t z0);
    longint         re;
    longint         im;
    longint         nre;
    longint         nim;
    logic [63:0]    re_sq;
    logic [63:0]    im_sq;
    int unsigned    k;
    int unsigned    idx;
    bit             escaped;
    logic [23:0]    rgb;
    jetc_pkg::out_t res;
    re      = longint'(z0.start_real);
    im      = longint'(z0.start_imag);
    escaped = 1'b0;
    for (k = 0; k < iter_limit; k++) begin
      nre   = clip_s32(((re * re - im * im) >>> FRAC_BITS) + c_re);
      nim   = clip_s32(((re * im) >>> (FRAC_BITS - 1)) + c_im);
      re    = nre;
      im    = nim;
      re_sq = re * re;
      im_sq = im * im;
      if (re_sq + im_sq > ESCAPE_MAG) begin
        escaped = 1'b1;
        break;
      end
    end
    res = '0;
    // escape on the very first step leaves the pixel unpainted, all fields zero
    if (!(escaped && k == 0)) begin
      idx               = escaped ? (k * (TABLE_LEN - 1)) / iter_limit : TABLE_LEN - 1;
      rgb               = shade(idx);
      res.red           = rgb[23:16];
      res.green         = rgb[15:8];
      res.blue          = rgb[7:0];
      res.painted       = 1'b1;
      res.escape_step   = escaped ? k[15:0] : iter_limit;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      fails++;
    end
  endtask

  // Track register writes, queue predictions on input beats, check output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_re       = longint'(jetc_pkg::C_REAL_RESET);
      c_im       = longint'(jetc_pkg::C_IMAG_RESET);
      iter_limit = 16'(jetc_pkg::MAX_ITER_RESET);
      colors_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          jetc_pkg::CFG_C_REAL:   c_re = longint'($signed(cfg_data_i));
          jetc_pkg::CFG_C_IMAG:   c_im = longint'($signed(cfg_data_i));
          jetc_pkg::CFG_MAX_ITER: iter_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        colors_due.push_back(color_point(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (colors_due.size() == 0) begin
          $error("output beat with no start point outstanding");
          fails++;
        end else begin
          want = colors_due.pop_front();
          check_field("red", want.red, out_data_i.red);
          check_field("green", want.green, out_data_i.green);
          check_field("blue", want.blue, out_data_i.blue);
          check_field("painted", want.painted, out_data_i.painted);
          check_field("escape_step", want.escape_step, out_data_i.escape_step);
        end
      end
    end
    pending_o    <= colors_due.size();
    fail_count_o <= fails;
  end

endmodule

### tb/tb_julia_escape_time_colorizer_unit.sv
`timescale 1ns / 100ps
// Testbench top for the colorizer: clock, reset, directed and random start points,
// register settings and output back-pressure; the verdict uses the checker's count.
// Depends on jetc_pkg, julia_escape_time_colorizer_unit and jetc_color_checker.
module tb_julia_escape_time_colorizer_unit;

  localparam int          RANDOM_ITEMS = 530;
  localparam int          HOLD_CYCLES  = 1500;
  localparam int          TAIL_CYCLES  = 600;
  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam logic [31:0] S32_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN      = 32'h8000_0000;
  localparam logic [31:0] FIX_ONE      = 32'h1000_0000;
  localparam logic [31:0] FIX_TWO      = 32'h2000_0000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  jetc_pkg::in_t  in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  jetc_pkg::out_t out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [1:0]     cfg_addr_i;
  logic [31:0]    cfg_data_i;

  int pending;
  int fail_count;

  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  bit hold_req   = 1'b0;

  julia_escape_time_colorizer_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  jetc_color_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] to_fix(input real x);
    return $rtoi(x * 268435456.0);
  endfunction

  // Uniform value in [-span, span]
  function automatic logic [31:0] span_rand(input logic [31:0] span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return 32'd0;
      3:       return 32'hffff_ffff;
      4:       return 32'd1;
      5:       return FIX_TWO;
      default: return -FIX_TWO;
    endcase
  endfunction

  function automatic jetc_pkg::in_t make_point(input logic [31:0] re, input logic [31:0] im);
    jetc_pkg::in_t pt;
    pt.start_real = re;
    pt.start_imag = im;
    return pt;
  endfunction

  // Mostly points near the set, some around the escape radius, some anywhere
  function automatic jetc_pkg::in_t random_point();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return make_point(span_rand(to_fix(1.6)), span_rand(to_fix(1.6)));
    if (r < 80) return make_point(span_rand(to_fix(2.1)), span_rand(to_fix(2.1)));
    if (r < 90) return make_point($urandom(), $urandom());
    return make_point(corner_value(), corner_value());
  endfunction

  // Julia constant: well-known shapes with jitter, a region around the set, or anything
  task automatic random_c(output logic [31:0] cr, output logic [31:0] ci);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      cr = $urandom();
      ci = $urandom();
    end else if (r < 50) begin
      case ($urandom_range(0, 5))
        0: begin cr = to_fix(-0.8);    ci = to_fix(0.156);   end
        1: begin cr = to_fix(0.285);   ci = to_fix(0.01);    end
        2: begin cr = to_fix(-0.4);    ci = to_fix(0.6);     end
        3: begin cr = to_fix(-0.7269); ci = to_fix(0.1889);  end
        4: begin cr = to_fix(0.355);   ci = to_fix(0.355);   end
        default: begin cr = to_fix(-0.835); ci = to_fix(-0.2321); end
      endcase
      cr = cr + span_rand(32'h0010_0000);
      ci = ci + span_rand(32'h0010_0000);
    end else begin
      cr = to_fix(-0.4) + span_rand(to_fix(0.85));
      ci = span_rand(to_fix(0.9));
    end
  endtask

  // One register write beat
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Upper bits of the iteration limit write carry junk; the register keeps 16 bits
  task automatic set_config(input logic [31:0] cr, input logic [31:0] ci,
                            input logic [15:0] limit);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 16'hffff));
    write_reg(jetc_pkg::CFG_C_REAL, cr);
    write_reg(jetc_pkg::CFG_C_IMAG, ci);
    write_reg(jetc_pkg::CFG_MAX_ITER, {junk, limit});
  endtask

  // Offer one start point beat and return at the edge that takes it
  task automatic send_point(input jetc_pkg::in_t pt);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted beat has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Output side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stall = rx_gaps_on ? pick_gap() : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int          i;
    int          n;
    int          sent;
    int          phase;
    logic [31:0] cr;
    logic [31:0] ci;
    logic [15:0] limit;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i  = jetc_pkg::CFG_C_REAL;
    cfg_data_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset constant: origin, corners, saturating starts, radius-two starts
    send_point(make_point(32'd0, 32'd0));
    send_point(make_point(S32_MAX, S32_MAX));
    send_point(make_point(S32_MIN, S32_MIN));
    send_point(make_point(S32_MAX, S32_MIN));
    send_point(make_point(S32_MIN, S32_MAX));
    send_point(make_point(S32_MAX, 32'd0));
    send_point(make_point(32'd0, S32_MIN));
    send_point(make_point(32'd1, 32'hffff_ffff));
    send_point(make_point(FIX_TWO, 32'd0));
    send_point(make_point(-FIX_TWO, FIX_TWO));
    send_point(make_point(to_fix(0.5), to_fix(0.5)));
    send_point(make_point(to_fix(-0.5), to_fix(0.3)));
    send_point(make_point(FIX_ONE, 32'd0));
    send_point(make_point(32'd0, FIX_ONE));
    send_point(make_point(-FIX_ONE, to_fix(-0.25)));
    drain_results();

    // c = -2: orbit of the origin sits on |z| = 2 exactly and never escapes
    set_config(-FIX_TWO, 32'd0, 16'd5);
    send_point(make_point(32'd0, 32'd0));
    drain_results();

    // c = +2: |z|^2 equals 4 after one step, escapes on the next; one LSB more escapes at once
    set_config(FIX_TWO, 32'd0, 16'd7);
    send_point(make_point(32'd0, 32'd0));
    drain_results();
    write_reg(jetc_pkg::CFG_C_REAL, FIX_TWO + 32'd1);
    send_point(make_point(32'd0, 32'd0));
    drain_results();

    // Extreme constant, single iteration
    set_config(S32_MAX, S32_MIN, 16'd1);
    send_point(make_point(32'd0, 32'd0));
    send_point(make_point(S32_MIN, 32'd0));
    drain_results();

    // Zero iteration limit: no step runs, the point counts as inside
    set_config(32'd0, 32'd0, 16'd0);
    send_point(make_point(32'd0, 32'd0));
    send_point(make_point(S32_MAX, S32_MAX));
    drain_results();

    // Full iteration limit: immediate escape, then a point that stays inside throughout
    set_config(S32_MIN, S32_MAX, 16'hffff);
    send_point(make_point(32'd0, 32'd0));
    drain_results();
    write_reg(jetc_pkg::CFG_C_REAL, 32'd0);
    write_reg(jetc_pkg::CFG_C_IMAG, 32'd0);
    send_point(make_point(to_fix(0.5), 32'd0));
    drain_results();

    // Random phases, each with its own constant and limit
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      random_c(cr, ci);
      n = $urandom_range(40, 80);
      if (phase == 3) begin
        limit = 16'd600;
        n     = 30;
      end else if (phase == 2) begin
        limit = 16'($urandom_range(8, 16));
      end else if ($urandom_range(0, 9) == 0) begin
        limit = 16'd1;
      end else begin
        limit = 16'($urandom_range(2, 64));
      end
      // every fourth phase runs back to back with no idling
      tx_gaps_on = (phase % 4 != 1);
      rx_gaps_on = (phase % 4 != 1);
      set_config(cr, ci, limit);
      for (i = 0; i < n; i++) begin
        send_point(random_point());
        // long output hold-off while the sender keeps offering beats
        if (phase == 2 && i == 5) hold_req = 1'b1;
      end
      drain_results();
      sent += n;
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
